@@ hdl/crb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crb_pkg
// shared constants, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package crb_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int DEF_SURFACES   = 2;

   // configuration registers
   localparam int NUM_REGS        = 5;
   localparam int REG_S0_WIDTH    = 0;
   localparam int REG_S0_HEIGHT   = 1;
   localparam int REG_S1_WIDTH    = 2;
   localparam int REG_S1_HEIGHT   = 3;
   localparam int REG_KEY_EXEMPT  = 4;
   localparam logic [10:0] RST_SURF_WIDTH  = 11'd640;
   localparam logic [10:0] RST_SURF_HEIGHT = 11'd480;
   localparam logic [10:0] RST_KEY_EXEMPT  = 11'd640;

   // request modes
   localparam logic [1:0] MODE_PIX_WRITE = 2'd0;
   localparam logic [1:0] MODE_PIX_READ  = 2'd1;
   localparam logic [1:0] MODE_FILL      = 2'd2;
   localparam logic [1:0] MODE_COPY      = 2'd3;

   // datapath commands
   localparam logic [3:0] CMD_NONE  = 4'd0;
   localparam logic [3:0] CMD_LOAD  = 4'd1;
   localparam logic [3:0] CMD_CLIPA = 4'd2;
   localparam logic [3:0] CMD_CLIPB = 4'd3;
   localparam logic [3:0] CMD_CLIPC = 4'd4;
   localparam logic [3:0] CMD_CLIPD = 4'd5;
   localparam logic [3:0] CMD_ADDR1 = 4'd6;
   localparam logic [3:0] CMD_ADDR2 = 4'd7;
   localparam logic [3:0] CMD_RUN   = 4'd8;
   localparam logic [3:0] CMD_PIX   = 4'd9;
   localparam logic [3:0] CMD_PIXD  = 4'd10;

   typedef logic signed [15:0] coord_type;

   typedef struct packed {
      logic [3:0] op;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic clip_empty;
      logic last;
   } status_type;

endpackage

@@ hdl/crb_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crb_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module crb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ hdl/crb_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crb_ctrl
// command sequencer: clip steps, address setup, pixel loop, response
// ----------------------------------------------------------------------------
module crb_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [1:0]          req_mode,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  crb_pkg::status_type status,
   output crb_pkg::cmd_type    cmd
);
   import crb_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CLIPA = 4'd1;
   localparam logic [3:0] S_CLIPB = 4'd2;
   localparam logic [3:0] S_CLIPC = 4'd3;
   localparam logic [3:0] S_CLIPD = 4'd4;
   localparam logic [3:0] S_ADDR1 = 4'd5;
   localparam logic [3:0] S_ADDR2 = 4'd6;
   localparam logic [3:0] S_RUN   = 4'd7;
   localparam logic [3:0] S_DRAIN = 4'd8;
   localparam logic [3:0] S_PIX   = 4'd9;
   localparam logic [3:0] S_PIXD  = 4'd10;
   localparam logic [3:0] S_RESP  = 4'd11;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] mode_ff, mode_in;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      cmd.op       = CMD_NONE;
      cmd.rsp_load = 1'b0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op  = CMD_LOAD;
               mode_in = req_mode;
               if (req_mode == MODE_COPY) begin
                  state_in = S_CLIPA;
               end else if (req_mode == MODE_FILL) begin
                  state_in = S_CLIPB;
               end else begin
                  state_in = S_PIX;
               end
            end
         end
         S_CLIPA: begin
            cmd.op   = CMD_CLIPA;
            state_in = S_CLIPB;
         end
         S_CLIPB: begin
            cmd.op   = CMD_CLIPB;
            state_in = (mode_ff == MODE_COPY) ? S_CLIPC : S_CLIPD;
         end
         S_CLIPC: begin
            cmd.op   = CMD_CLIPC;
            state_in = S_CLIPD;
         end
         S_CLIPD: begin
            cmd.op   = CMD_CLIPD;
            state_in = S_ADDR1;
         end
         S_ADDR1: begin
            cmd.op   = CMD_ADDR1;
            state_in = status.clip_empty ? S_RESP : S_ADDR2;
         end
         S_ADDR2: begin
            cmd.op   = CMD_ADDR2;
            state_in = S_RUN;
         end
         S_RUN: begin
            cmd.op = CMD_RUN;
            if (status.last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_RESP;
         end
         S_PIX: begin
            cmd.op   = CMD_PIX;
            state_in = S_PIXD;
         end
         S_PIXD: begin
            cmd.op   = CMD_PIXD;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_PIX_WRITE;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ hdl/crb_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crb_dp
// datapath: config registers, clipping, address generation, store access
// ----------------------------------------------------------------------------
module crb_dp #(
   parameter int MAX_WIDTH  = crb_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = crb_pkg::DEF_MAX_HEIGHT,
   parameter int SURFACES   = crb_pkg::DEF_SURFACES,
   parameter int AW         = $clog2(SURFACES * MAX_HEIGHT * MAX_WIDTH)
) (
   input  logic                clock,
   input  logic                reset,
   input  crb_pkg::cmd_type    cmd,
   output crb_pkg::status_type status,
   input  logic                csr_write,
   input  logic [2:0]          csr_index,
   input  logic [10:0]         csr_data,
   input  logic [1:0]          req_mode,
   input  logic                req_dst_surface,
   input  logic                req_src_surface,
   input  logic signed [11:0]  req_rect_x,
   input  logic signed [11:0]  req_rect_y,
   input  logic signed [11:0]  req_rect_w,
   input  logic signed [11:0]  req_rect_h,
   input  logic signed [11:0]  req_dst_x,
   input  logic signed [11:0]  req_dst_y,
   input  logic [7:0]          req_pixel_value,
   input  logic                req_keyed,
   input  logic                req_full_rect,
   output logic                ram_we,
   output logic [AW-1:0]       ram_waddr,
   output logic [7:0]          ram_wdata,
   output logic [AW-1:0]       ram_raddr,
   input  logic [7:0]          ram_rdata,
   output logic [7:0]          rsp_read_value,
   output logic                rsp_nothing_drawn
);
   import crb_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   logic [10:0] cfg_ff [NUM_REGS];
   logic [10:0] cfg_in [NUM_REGS];

   logic [1:0]    mode_ff, mode_in;
   logic          ds_ff, ds_in, ss_ff, ss_in;
   logic [7:0]    pv_ff, pv_in;
   logic          keyed_ff, keyed_in;
   coord_type     sx_ff, sx_in, sy_ff, sy_in, dx_ff, dx_in, dy_ff, dy_in;
   coord_type     w_ff, w_in, h_ff, h_in, orig_w_ff, orig_w_in;
   logic [AW-1:0] src_base_ff, src_base_in, dst_base_ff, dst_base_in;
   logic [AW-1:0] off_ff, off_in, jump_ff, jump_in;
   logic [AW-1:0] src_addr_ff, src_addr_in, dst_addr_ff, dst_addr_in;
   logic [AW-1:0] p_dst_ff, p_dst_in;
   logic          rev_ff, rev_in, p_valid_ff, p_valid_in, inside_ff, inside_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic          res_empty_ff, res_empty_in, rsp_empty_ff, rsp_empty_in;
   logic [7:0]    res_val_ff, res_val_in, rsp_val_ff, rsp_val_in;

   coord_type     dw, dh, sw, sh, req_dw, req_dh, req_sw, req_sh;
   logic [AW-1:0] pix_a;
   logic          pix_hit, skip0;

   function automatic coord_type clamp_size(input logic [10:0] v, input int lim);
      if (int'(v) > lim) begin
         return coord_type'(lim);
      end
      return coord_type'({5'b0, v});
   endfunction

   function automatic coord_type surf_w(input logic s);
      if (int'(s) >= SURFACES) begin
         return '0;
      end
      return s ? clamp_size(cfg_ff[REG_S1_WIDTH], MAX_WIDTH)
               : clamp_size(cfg_ff[REG_S0_WIDTH], MAX_WIDTH);
   endfunction

   function automatic coord_type surf_h(input logic s);
      if (int'(s) >= SURFACES) begin
         return '0;
      end
      return s ? clamp_size(cfg_ff[REG_S1_HEIGHT], MAX_HEIGHT)
               : clamp_size(cfg_ff[REG_S0_HEIGHT], MAX_HEIGHT);
   endfunction

   // linear store address, row pitch of one maximal surface row
   function automatic logic [AW-1:0] pix_addr(input logic s, input coord_type x,
                                             input coord_type y);
      logic [AW-1:0] row;
      row = AW'(s) * AW'(MAX_HEIGHT) + AW'(y);
      return row * AW'(MAX_WIDTH) + AW'(x);
   endfunction

   always_comb begin
      dw      = surf_w(ds_ff);
      dh      = surf_h(ds_ff);
      sw      = surf_w(ss_ff);
      sh      = surf_h(ss_ff);
      req_dw  = surf_w(req_dst_surface);
      req_dh  = surf_h(req_dst_surface);
      req_sw  = surf_w(req_src_surface);
      req_sh  = surf_h(req_src_surface);
      pix_a   = pix_addr(ds_ff, dx_ff, dy_ff);
      pix_hit = (dx_ff >= 0) && (dy_ff >= 0) && (dx_ff < dw) && (dy_ff < dh);
      skip0   = keyed_ff && (orig_w_ff != coord_type'({5'b0, cfg_ff[REG_KEY_EXEMPT]}));
   end

   assign status.clip_empty = (w_ff <= 0) || (h_ff <= 0);
   assign status.last       = (col_ff == '0) && (row_ff == '0);

   // store ports
   always_comb begin
      ram_raddr = (cmd.op == CMD_PIX) ? pix_a : src_addr_ff;
      if (cmd.op == CMD_PIX) begin
         ram_we    = pix_hit && (mode_ff == MODE_PIX_WRITE);
         ram_waddr = pix_a;
         ram_wdata = pv_ff;
      end else if (cmd.op == CMD_RUN && mode_ff == MODE_FILL) begin
         ram_we    = 1'b1;
         ram_waddr = dst_addr_ff;
         ram_wdata = pv_ff;
      end else begin
         ram_we    = p_valid_ff && !(skip0 && ram_rdata == 8'd0);
         ram_waddr = p_dst_ff;
         ram_wdata = ram_rdata;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      for (int i = 0; i < NUM_REGS; i++) begin
         if (csr_write && csr_index == 3'(i)) begin
            cfg_in[i] = csr_data;
         end
      end

      mode_in      = mode_ff;
      ds_in        = ds_ff;
      ss_in        = ss_ff;
      pv_in        = pv_ff;
      keyed_in     = keyed_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      orig_w_in    = orig_w_ff;
      src_base_in  = src_base_ff;
      dst_base_in  = dst_base_ff;
      off_in       = off_ff;
      jump_in      = jump_ff;
      src_addr_in  = src_addr_ff;
      dst_addr_in  = dst_addr_ff;
      rev_in       = rev_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      inside_in    = inside_ff;
      res_empty_in = res_empty_ff;
      res_val_in   = res_val_ff;
      p_valid_in   = (cmd.op == CMD_RUN) && (mode_ff == MODE_COPY);
      p_dst_in     = dst_addr_ff;

      case (cmd.op)
         CMD_LOAD: begin
            mode_in      = req_mode;
            ds_in        = req_dst_surface;
            ss_in        = req_src_surface;
            pv_in        = req_pixel_value;
            keyed_in     = req_keyed;
            res_empty_in = 1'b0;
            res_val_in   = 8'd0;
            sx_in        = coord_type'(req_rect_x);
            sy_in        = coord_type'(req_rect_y);
            w_in         = coord_type'(req_rect_w);
            h_in         = coord_type'(req_rect_h);
            dx_in        = coord_type'(req_dst_x);
            dy_in        = coord_type'(req_dst_y);
            if (req_mode == MODE_FILL) begin
               // fill rectangle lives in destination coordinates
               dx_in = coord_type'(req_rect_x);
               dy_in = coord_type'(req_rect_y);
               if (req_full_rect) begin
                  dx_in = '0;
                  dy_in = '0;
                  w_in  = req_dw;
                  h_in  = req_dh;
               end
            end else if (req_mode == MODE_COPY && req_full_rect) begin
               sx_in = '0;
               sy_in = '0;
               w_in  = req_sw;
               h_in  = req_sh;
            end
            orig_w_in = w_in;
         end
         CMD_CLIPA: begin
            if (sx_ff < 0) begin
               dx_in = dx_ff - sx_ff;
               w_in  = w_ff + sx_ff;
               sx_in = '0;
            end
            if (sy_ff < 0) begin
               dy_in = dy_ff - sy_ff;
               h_in  = h_ff + sy_ff;
               sy_in = '0;
            end
         end
         CMD_CLIPB: begin
            if (dx_ff < 0) begin
               sx_in = sx_ff - dx_ff;
               w_in  = w_ff + dx_ff;
               dx_in = '0;
            end
            if (dy_ff < 0) begin
               sy_in = sy_ff - dy_ff;
               h_in  = h_ff + dy_ff;
               dy_in = '0;
            end
         end
         CMD_CLIPC: begin
            if (sx_ff + w_ff > sw) begin
               w_in = sw - sx_ff;
            end
            if (sy_ff + h_ff > sh) begin
               h_in = sh - sy_ff;
            end
         end
         CMD_CLIPD: begin
            if (dx_ff + w_ff > dw) begin
               w_in = dw - dx_ff;
            end
            if (dy_ff + h_ff > dh) begin
               h_in = dh - dy_ff;
            end
         end
         CMD_ADDR1: begin
            src_base_in = pix_addr(ss_ff, sx_ff, sy_ff);
            dst_base_in = pix_addr(ds_ff, dx_ff, dy_ff);
            off_in      = AW'(h_ff - 16'sd1) * AW'(MAX_WIDTH) + AW'(w_ff - 16'sd1);
            jump_in     = AW'(MAX_WIDTH) - AW'(w_ff) + AW'(1);
            if (status.clip_empty) begin
               res_empty_in = 1'b1;
            end
         end
         CMD_ADDR2: begin
            // overlapping copy forward in the store walks backward
            rev_in      = (mode_ff == MODE_COPY) && (ss_ff == ds_ff) &&
                          (dst_base_ff > src_base_ff);
            src_addr_in = rev_in ? src_base_ff + off_ff : src_base_ff;
            dst_addr_in = rev_in ? dst_base_ff + off_ff : dst_base_ff;
            col_in      = CW'(w_ff - 16'sd1);
            row_in      = RW'(h_ff - 16'sd1);
         end
         CMD_RUN: begin
            if (col_ff == '0) begin
               col_in      = CW'(w_ff - 16'sd1);
               row_in      = row_ff - RW'(1);
               src_addr_in = rev_ff ? src_addr_ff - jump_ff : src_addr_ff + jump_ff;
               dst_addr_in = rev_ff ? dst_addr_ff - jump_ff : dst_addr_ff + jump_ff;
            end else begin
               col_in      = col_ff - CW'(1);
               src_addr_in = rev_ff ? src_addr_ff - AW'(1) : src_addr_ff + AW'(1);
               dst_addr_in = rev_ff ? dst_addr_ff - AW'(1) : dst_addr_ff + AW'(1);
            end
         end
         CMD_PIX: begin
            inside_in    = pix_hit;
            res_empty_in = !pix_hit;
         end
         CMD_PIXD: begin
            res_val_in = (inside_ff && mode_ff == MODE_PIX_READ) ? ram_rdata : 8'd0;
         end
         default: begin
         end
      endcase

      rsp_val_in   = cmd.rsp_load ? res_val_ff : rsp_val_ff;
      rsp_empty_in = cmd.rsp_load ? res_empty_ff : rsp_empty_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[REG_S0_WIDTH]   <= RST_SURF_WIDTH;
         cfg_ff[REG_S0_HEIGHT]  <= RST_SURF_HEIGHT;
         cfg_ff[REG_S1_WIDTH]   <= RST_SURF_WIDTH;
         cfg_ff[REG_S1_HEIGHT]  <= RST_SURF_HEIGHT;
         cfg_ff[REG_KEY_EXEMPT] <= RST_KEY_EXEMPT;
         p_valid_ff             <= 1'b0;
      end else begin
         cfg_ff     <= cfg_in;
         p_valid_ff <= p_valid_in;
      end
      mode_ff      <= mode_in;
      ds_ff        <= ds_in;
      ss_ff        <= ss_in;
      pv_ff        <= pv_in;
      keyed_ff     <= keyed_in;
      sx_ff        <= sx_in;
      sy_ff        <= sy_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      w_ff         <= w_in;
      h_ff         <= h_in;
      orig_w_ff    <= orig_w_in;
      src_base_ff  <= src_base_in;
      dst_base_ff  <= dst_base_in;
      off_ff       <= off_in;
      jump_ff      <= jump_in;
      src_addr_ff  <= src_addr_in;
      dst_addr_ff  <= dst_addr_in;
      rev_ff       <= rev_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      inside_ff    <= inside_in;
      res_empty_ff <= res_empty_in;
      res_val_ff   <= res_val_in;
      p_dst_ff     <= p_dst_in;
      rsp_val_ff   <= rsp_val_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp_read_value    = rsp_val_ff;
   assign rsp_nothing_drawn = rsp_empty_ff;

endmodule

@@ hdl/clipped_rect_blitter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_rect_blitter
// 8bpp indexed blitter with clipping and color-keyed copy over a pixel store
// ----------------------------------------------------------------------------
// pixel write/read: steps PIX and PIXD, then RESP registers the response; the next request waits for idle
// rectangle fill: clip steps B and D, copy: clip steps A to D, then address setup, the
//   pixel loop, a drain step and RESP; one pixel per cycle through the
//   single write port of the pixel store; clipped-empty ones go from address setup to RESP
// reset: synchronous; config registers to defaults, pixel store not cleared
// a new request is taken while the previous response still waits
module clipped_rect_blitter #(
   parameter int MAX_WIDTH  = crb_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = crb_pkg::DEF_MAX_HEIGHT,
   parameter int SURFACES   = crb_pkg::DEF_SURFACES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_mode,
   input  logic               req_dst_surface,
   input  logic               req_src_surface,
   input  logic signed [11:0] req_rect_x,
   input  logic signed [11:0] req_rect_y,
   input  logic signed [11:0] req_rect_w,
   input  logic signed [11:0] req_rect_h,
   input  logic signed [11:0] req_dst_x,
   input  logic signed [11:0] req_dst_y,
   input  logic [7:0]         req_pixel_value,
   input  logic               req_keyed,
   input  logic               req_full_rect,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_read_value,
   output logic               rsp_nothing_drawn,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [10:0]        csr_data
);
   import crb_pkg::*;

   localparam int DEPTH = SURFACES * MAX_HEIGHT * MAX_WIDTH;
   localparam int AW    = $clog2(DEPTH);

   cmd_type       cmd;
   status_type    status;
   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [7:0]    ram_wdata, ram_rdata;

   // registers are always writable
   assign csr_ready = 1'b1;

   // sequencer: clip steps, address setup, pixel loop, response handoff
   crb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // clipping arithmetic, address walk, config registers, response data
   crb_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .SURFACES   (SURFACES),
      .AW         (AW)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_write         (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_mode          (req_mode),
      .req_dst_surface   (req_dst_surface),
      .req_src_surface   (req_src_surface),
      .req_rect_x        (req_rect_x),
      .req_rect_y        (req_rect_y),
      .req_rect_w        (req_rect_w),
      .req_rect_h        (req_rect_h),
      .req_dst_x         (req_dst_x),
      .req_dst_y         (req_dst_y),
      .req_pixel_value   (req_pixel_value),
      .req_keyed         (req_keyed),
      .req_full_rect     (req_full_rect),
      .ram_we            (ram_we),
      .ram_waddr         (ram_waddr),
      .ram_wdata         (ram_wdata),
      .ram_raddr         (ram_raddr),
      .ram_rdata         (ram_rdata),
      .rsp_read_value    (rsp_read_value),
      .rsp_nothing_drawn (rsp_nothing_drawn)
   );

   // pixel store, all surfaces back to back with a full-width row pitch
   crb_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // the block is not ready again in the cycle after taking a request
   a_busy_after_accept: assert property (
      @(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready
   ) else $error("request taken back to back");

   // no store writes while waiting for a request
   a_no_write_idle: assert property (
      @(posedge clock) disable iff (reset)
      req_ready |-> !ram_we
   ) else $error("pixel store written while idle");

   // a response appears only when a request had been taken
   a_rsp_after_req: assert property (
      @(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready)
   ) else $error("response without request");

endmodule

@@ sim/clipped_rect_blitter_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_rect_blitter_test
// self-checking bench: table of directed requests, then random command
// streams over several surface settings, every response checked against a
// hand value or a pixel-accurate software image of the store
// ----------------------------------------------------------------------------
module clipped_rect_blitter_test;
   import crb_pkg::*;

   localparam int PITCH = DEF_MAX_WIDTH;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      logic [1:0]         mode;
      logic               dst_surface;
      logic               src_surface;
      logic signed [11:0] rect_x;
      logic signed [11:0] rect_y;
      logic signed [11:0] rect_w;
      logic signed [11:0] rect_h;
      logic signed [11:0] dst_x;
      logic signed [11:0] dst_y;
      logic [7:0]         pixel_value;
      logic               keyed;
      logic               full_rect;
   } blit_req_type;

   typedef struct {
      logic [7:0] read_value;
      logic       nothing_drawn;
   } blit_rsp_type;

   typedef struct {
      blit_req_type req;
      bit           known;
      blit_rsp_type rsp;
   } stim_row_type;

   logic clock = 0;
   logic reset = 1;

   logic               req_valid = 0;
   logic               req_ready;
   logic [1:0]         req_mode = MODE_PIX_WRITE;
   logic               req_dst_surface = 0;
   logic               req_src_surface = 0;
   logic signed [11:0] req_rect_x = 0;
   logic signed [11:0] req_rect_y = 0;
   logic signed [11:0] req_rect_w = 0;
   logic signed [11:0] req_rect_h = 0;
   logic signed [11:0] req_dst_x = 0;
   logic signed [11:0] req_dst_y = 0;
   logic [7:0]         req_pixel_value = 0;
   logic               req_keyed = 0;
   logic               req_full_rect = 0;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   logic [7:0]         rsp_read_value;
   logic               rsp_nothing_drawn;
   logic               csr_valid = 0;
   logic               csr_ready;
   logic [2:0]         csr_index = 0;
   logic [10:0]        csr_data = 0;

   // software image of the pixel store; only written entries exist
   logic [7:0]   pixel_image[int];
   int           surf_reg[NUM_REGS];
   blit_rsp_type pending_rsp[$];
   stim_row_type dir_tab[$];

   int  fail_count = 0;
   int  rsp_count = 0;
   int  mode_count[4] = '{0, 0, 0, 0};
   int  empty_count = 0;
   int  burst_left = 0;
   bit  hold_trig = 0;

   clipped_rect_blitter DUT (.*);

   // clock and reset
   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 0;
   end

   // hard limit on run length
   initial begin
      #100_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // ---------------------------------------------------------------------
   // pixel store predictor
   // ---------------------------------------------------------------------

   // size of a surface, saturated to the store geometry
   function automatic int surf_w(logic s);
      return (surf_reg[s * 2] > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : surf_reg[s * 2];
   endfunction

   function automatic int surf_h(logic s);
      return (surf_reg[s * 2 + 1] > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT
                                                    : surf_reg[s * 2 + 1];
   endfunction

   function automatic int pix_addr(logic s, int x, int y);
      return (int'(s) * DEF_MAX_HEIGHT + y) * PITCH + x;
   endfunction

   // computes the response of one request; with apply set the image is
   // updated too; returns 0 if the request would read a never-written pixel
   function automatic bit blit_predict(input blit_req_type r, input bit apply,
                                       output blit_rsp_type rsp);
      int rx, ry, rw, rh, dx, dy, dw, dh, sw, sh, sx, sy, w, h, orig_w, a;
      bit ok;
      bit skip0;
      logic [7:0] snap[$];
      rx = r.rect_x;  ry = r.rect_y;  rw = r.rect_w;  rh = r.rect_h;
      dx = r.dst_x;   dy = r.dst_y;
      dw = surf_w(r.dst_surface);
      dh = surf_h(r.dst_surface);
      ok = 1;
      rsp.read_value = 0;
      rsp.nothing_drawn = 0;
      case (r.mode)
         MODE_PIX_WRITE, MODE_PIX_READ: begin
            if (dx < 0 || dy < 0 || dx >= dw || dy >= dh) begin
               rsp.nothing_drawn = 1;
            end else if (r.mode == MODE_PIX_WRITE) begin
               if (apply) pixel_image[pix_addr(r.dst_surface, dx, dy)] = r.pixel_value;
            end else begin
               a = pix_addr(r.dst_surface, dx, dy);
               if (pixel_image.exists(a)) rsp.read_value = pixel_image[a];
               else ok = 0;
            end
         end
         MODE_FILL: begin
            if (r.full_rect) begin
               rx = 0; ry = 0; rw = dw; rh = dh;
            end
            if (rx < 0) begin rw += rx; rx = 0; end
            if (ry < 0) begin rh += ry; ry = 0; end
            if (rx + rw > dw) rw = dw - rx;
            if (ry + rh > dh) rh = dh - ry;
            if (rw <= 0 || rh <= 0) rsp.nothing_drawn = 1;
            else if (apply) begin
               for (int j = 0; j < rh; j++)
                  for (int i = 0; i < rw; i++)
                     pixel_image[pix_addr(r.dst_surface, rx + i, ry + j)] = r.pixel_value;
            end
         end
         default: begin
            sw = surf_w(r.src_surface);
            sh = surf_h(r.src_surface);
            if (r.full_rect) begin
               rx = 0; ry = 0; rw = sw; rh = sh;
            end
            orig_w = rw;
            sx = rx; sy = ry; w = rw; h = rh;
            // negative starts move source and destination together
            if (sx < 0) begin dx -= sx; w += sx; sx = 0; end
            if (sy < 0) begin dy -= sy; h += sy; sy = 0; end
            if (dx < 0) begin sx -= dx; w += dx; dx = 0; end
            if (dy < 0) begin sy -= dy; h += dy; dy = 0; end
            if (sx + w > sw) w = sw - sx;
            if (sy + h > sh) h = sh - sy;
            if (dx + w > dw) w = dw - dx;
            if (dy + h > dh) h = dh - dy;
            if (w <= 0 || h <= 0) begin
               rsp.nothing_drawn = 1;
            end else begin
               // source taken as a whole first, so overlapping copies are safe
               for (int j = 0; j < h; j++)
                  for (int i = 0; i < w; i++) begin
                     a = pix_addr(r.src_surface, sx + i, sy + j);
                     if (pixel_image.exists(a)) snap.push_back(pixel_image[a]);
                     else begin
                        ok = 0;
                        snap.push_back(8'h00);
                     end
                  end
               skip0 = r.keyed && orig_w != surf_reg[REG_KEY_EXEMPT];
               if (apply && ok) begin
                  for (int j = 0; j < h; j++)
                     for (int i = 0; i < w; i++)
                        if (!skip0 || snap[j * w + i] != 8'h00)
                           pixel_image[pix_addr(r.dst_surface, dx + i, dy + j)] =
                              snap[j * w + i];
               end
            end
         end
      endcase
      return ok;
   endfunction

   // ---------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------

   // offers one request in bursts with random gaps, then records what the
   // response must be once the block takes it
   task automatic send_request(input blit_req_type r, input bit known,
                               input blit_rsp_type typed);
      blit_rsp_type pred;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      req_mode        <= r.mode;
      req_dst_surface <= r.dst_surface;
      req_src_surface <= r.src_surface;
      req_rect_x      <= r.rect_x;
      req_rect_y      <= r.rect_y;
      req_rect_w      <= r.rect_w;
      req_rect_h      <= r.rect_h;
      req_dst_x       <= r.dst_x;
      req_dst_y       <= r.dst_y;
      req_pixel_value <= r.pixel_value;
      req_keyed       <= r.keyed;
      req_full_rect   <= r.full_rect;
      req_valid       <= 1;
      do @(posedge clock); while (!req_ready);
      void'(blit_predict(r, 1, pred));
      // typed-in rows check against the hand value, the rest against the image
      pending_rsp.push_back(known ? typed : pred);
      mode_count[r.mode]++;
   endtask

   // waits for the block to drain and go quiet
   task automatic wait_idle();
      req_valid <= 0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // register writes, only while nothing is outstanding
   task automatic set_surfaces(input int w0, h0, w1, h1, key);
      int vals[NUM_REGS];
      vals = '{w0, h0, w1, h1, key};
      wait_idle();
      for (int i = 0; i < NUM_REGS; i++) begin
         csr_index <= i[2:0];
         csr_data  <= vals[i][10:0];
         csr_valid <= 1;
         do @(posedge clock); while (!csr_ready);
         surf_reg[i] = vals[i] & 11'h7ff;
      end
      csr_valid <= 0;
      @(posedge clock);
   endtask

   function automatic blit_req_type mk_req(int mode, ds, ss, rx, ry, rw, rh,
                                           dx, dy, pv, key, full);
      blit_req_type r;
      r.mode = mode[1:0];
      r.dst_surface = ds[0];
      r.src_surface = ss[0];
      r.rect_x = rx[11:0];  r.rect_y = ry[11:0];
      r.rect_w = rw[11:0];  r.rect_h = rh[11:0];
      r.dst_x = dx[11:0];   r.dst_y = dy[11:0];
      r.pixel_value = pv[7:0];
      r.keyed = key[0];
      r.full_rect = full[0];
      return r;
   endfunction

   function automatic void add_row(blit_req_type r, bit known, int rv, int nd);
      stim_row_type row;
      row.req = r;
      row.known = known;
      row.rsp.read_value = rv[7:0];
      row.rsp.nothing_drawn = nd[0];
      dir_tab.push_back(row);
   endfunction

   // coordinate near a span, now and then anything at all
   function automatic int rnd_coord(int lo, int hi);
      if ($urandom_range(0, 7) == 0) return int'($signed(12'($urandom)));
      return lo + int'($urandom_range(hi - lo, 0));
   endfunction

   function automatic blit_req_type rnd_req();
      blit_req_type r;
      int span;
      r.mode = 2'($urandom_range(0, 3));
      r.dst_surface = 1'($urandom);
      r.src_surface = 1'($urandom);
      span = (surf_w(1'b0) > surf_w(1'b1)) ? surf_w(1'b0) : surf_w(1'b1);
      r.rect_x = 12'(rnd_coord(-10, span + 4));
      r.dst_x  = 12'(rnd_coord(-10, span + 4));
      span = (surf_h(1'b0) > surf_h(1'b1)) ? surf_h(1'b0) : surf_h(1'b1);
      r.rect_y = 12'(rnd_coord(-10, span + 4));
      r.dst_y  = 12'(rnd_coord(-10, span + 4));
      r.rect_w = 12'(rnd_coord(-4, 24));
      r.rect_h = 12'(rnd_coord(-4, 24));
      // width equal to the exemption register turns keyed copy off
      if ($urandom_range(0, 5) == 0) r.rect_w = 12'(surf_reg[REG_KEY_EXEMPT]);
      // zero pixels feed the color key
      r.pixel_value = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
      r.keyed = 1'($urandom);
      r.full_rect = ($urandom_range(0, 9) == 0);
      return r;
   endfunction

   task automatic run_random(input int count);
      blit_req_type r;
      blit_rsp_type dummy;
      dummy = '{8'h00, 1'b0};
      repeat (count) begin
         r = rnd_req();
         // never touch a pixel that was never written
         if (!blit_predict(r, 0, dummy)) r.mode = MODE_PIX_WRITE;
         send_request(r, 0, dummy);
      end
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      surf_reg = '{int'(RST_SURF_WIDTH), int'(RST_SURF_HEIGHT),
                   int'(RST_SURF_WIDTH), int'(RST_SURF_HEIGHT), int'(RST_KEY_EXEMPT)};

      // directed part at the reset sizes, 640 by 480 on both surfaces
      add_row(mk_req(MODE_PIX_WRITE, 0, 0, 0, 0, 0, 0, 0, 0, 'hab, 0, 0), 1, 0, 0);
      add_row(mk_req(MODE_PIX_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 'hab, 0);
      // far corner of surface one
      add_row(mk_req(MODE_PIX_WRITE, 1, 0, 0, 0, 0, 0, 639, 479, 'hff, 0, 0), 1, 0, 0);
      add_row(mk_req(MODE_PIX_READ, 1, 0, 0, 0, 0, 0, 639, 479, 0, 0, 0), 1, 'hff, 0);
      // pixel outside the surface on the right, left and bottom
      add_row(mk_req(MODE_PIX_WRITE, 0, 0, 0, 0, 0, 0, 640, 0, 'h12, 0, 0), 1, 0, 1);
      add_row(mk_req(MODE_PIX_READ, 0, 0, 0, 0, 0, 0, -1, 0, 0, 0, 0), 1, 0, 1);
      add_row(mk_req(MODE_PIX_READ, 1, 0, 0, 0, 0, 0, 0, 480, 0, 0, 0), 1, 0, 1);
      add_row(mk_req(MODE_PIX_WRITE, 1, 1, 0, 0, 0, 0, -2048, 2047, 'h5a, 1, 1),
              1, 0, 1);
      // fill clipped at the top-left, then empty fills
      add_row(mk_req(MODE_FILL, 0, 0, -5, -5, 10, 10, 0, 0, 'h07, 0, 0), 1, 0, 0);
      add_row(mk_req(MODE_FILL, 0, 0, 3, 3, 0, 4, 0, 0, 'h09, 0, 0), 1, 0, 1);
      add_row(mk_req(MODE_FILL, 1, 0, 0, 0, 5, -2048, 0, 0, 'h09, 0, 0), 1, 0, 1);
      // fill clipped at the bottom-right by the largest sizes
      add_row(mk_req(MODE_FILL, 0, 0, 630, 470, 2047, 2047, 0, 0, 'h55, 0, 0), 1, 0, 0);
      add_row(mk_req(MODE_FILL, 1, 0, 2047, 0, 4, 4, 0, 0, 'h33, 0, 0), 1, 0, 1);
      add_row(mk_req(MODE_PIX_READ, 0, 0, 0, 0, 0, 0, 635, 475, 0, 0, 0), 1, 'h55, 0);
      // a zero in the source for the keyed copies
      add_row(mk_req(MODE_PIX_WRITE, 0, 0, 0, 0, 0, 0, 1, 1, 'h00, 0, 0), 1, 0, 0);
      // copies: negative destination, overlap within one surface, negative source
      add_row(mk_req(MODE_COPY, 1, 0, 0, 0, 5, 5, -2, -3, 0, 0, 0), 0, 0, 0);
      add_row(mk_req(MODE_COPY, 0, 0, 0, 0, 5, 5, 2, 1, 0, 1, 0), 0, 0, 0);
      add_row(mk_req(MODE_COPY, 1, 0, -3, -2, 8, 7, 10, 10, 0, 1, 0), 0, 0, 0);
      add_row(mk_req(MODE_COPY, 1, 0, 0, 0, -1, 5, 0, 0, 0, 0, 0), 1, 0, 1);
      add_row(mk_req(MODE_PIX_READ, 0, 0, 0, 0, 0, 0, 2, 1, 0, 0, 0), 0, 0, 0);
      add_row(mk_req(MODE_PIX_READ, 1, 0, 0, 0, 0, 0, 13, 12, 0, 0, 0), 0, 0, 0);
      // copy clipped down to one pixel at the far corner
      add_row(mk_req(MODE_COPY, 0, 1, 0, 0, 3, 2, 639, 479, 0, 0, 0), 0, 0, 0);

      @(posedge clock);
      while (reset) @(posedge clock);
      foreach (dir_tab[i]) send_request(dir_tab[i].req, dir_tab[i].known, dir_tab[i].rsp);

      // small surfaces, exemption width equal to surface zero's width
      set_surfaces(32, 24, 20, 40, 32);
      send_request(mk_req(MODE_FILL, 0, 0, 0, 0, 0, 0, 0, 0, 'h11, 0, 1), 0, '{0, 0});
      send_request(mk_req(MODE_FILL, 1, 0, 0, 0, 0, 0, 0, 0, 'h00, 0, 1), 0, '{0, 0});
      // long receiver hold-off while requests keep coming
      hold_trig = 1;
      run_random(450);

      // zero-width surface and an oversized one, exemption width zero
      set_surfaces(0, 1024, 2047, 3, 0);
      send_request(mk_req(MODE_FILL, 1, 0, 0, 0, 0, 0, 0, 0, 'h22, 0, 1), 0, '{0, 0});
      run_random(330);

      // tall narrow surface, exemption at its largest
      set_surfaces(1, 1024, 16, 16, 2047);
      send_request(mk_req(MODE_FILL, 0, 0, 0, 0, 0, 0, 0, 0, 'h44, 0, 1), 0, '{0, 0});
      send_request(mk_req(MODE_FILL, 1, 0, 0, 0, 0, 0, 0, 0, 'h00, 0, 1), 0, '{0, 0});
      run_random(330);

      wait_idle();
      $display("checked %0d responses: %0d writes, %0d reads, %0d fills, %0d copies",
               rsp_count, mode_count[0], mode_count[1], mode_count[2], mode_count[3]);
      $display("%0d responses reported nothing drawn, over four surface settings",
               empty_count);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // response side: stall pattern, long hold-off, field checks
   // ---------------------------------------------------------------------
   initial begin
      blit_rsp_type want;
      int hold_left;
      int pattern;
      int phase_left;
      hold_left = 0;
      pattern = 0;
      phase_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (rsp_nothing_drawn) empty_count++;
            if (pending_rsp.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_read_value !== want.read_value) begin
                  $error("read_value expected %0h actual %0h", want.read_value,
                         rsp_read_value);
                  fail_count++;
               end
               if (rsp_nothing_drawn !== want.nothing_drawn) begin
                  $error("nothing_drawn expected %0b actual %0b", want.nothing_drawn,
                         rsp_nothing_drawn);
                  fail_count++;
               end
            end
         end
         // pick a new stall pattern now and then: always ready, sparse, coin
         if (phase_left == 0) begin
            pattern = $urandom_range(0, 2);
            phase_left = $urandom_range(20, 200);
         end
         phase_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 0;
         end else if (hold_trig) begin
            hold_trig = 0;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 0;
         end else begin
            case (pattern)
               0: rsp_ready <= 1;
               1: rsp_ready <= (phase_left % 4 == 0);
               default: rsp_ready <= 1'($urandom);
            endcase
         end
      end
   end

endmodule
